### hdl/rse_pkg.sv
`default_nettype none
package rse_pkg;

  localparam int unsigned SymW     = 8;
  localparam int unsigned PcW      = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [PcW-1:0]  PARITY_RESET = 6'd8;
  localparam logic [SymW-1:0] POLY_RESET   = 8'h1d;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PARITY_COUNT = 2'd0,
    REG_FIELD_POLY   = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic [SymW-1:0] data_byte;
    logic            last_data;
  } item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // GF(256) product modulo x^8 + poly, shift and add
  function automatic logic [SymW-1:0] gf_mul(input logic [SymW-1:0] x,
                                             input logic [SymW-1:0] y,
                                             input logic [SymW-1:0] poly);
    logic [SymW-1:0] a;
    logic [SymW-1:0] p;
    a = x;
    p = '0;
    for (int k = 0; k < SymW; k++) begin
      if (y[k]) p = p ^ a;
      a = a[SymW-1] ? ({a[SymW-2:0], 1'b0} ^ poly) : {a[SymW-2:0], 1'b0};
    end
    return p;
  endfunction

endpackage
`default_nettype wire

### hdl/rse_in_if.sv
`default_nettype none
interface rse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_data;
  modport source (output valid, output data_byte, output last_data, input ready);
  modport sink   (input valid, input data_byte, input last_data, output ready);
endinterface
`default_nettype wire

### hdl/rse_out_if.sv
`default_nettype none
interface rse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] parity_byte;
  logic       last_parity;
  modport source (output valid, output parity_byte, output last_parity, input ready);
  modport sink   (input valid, input parity_byte, input last_parity, output ready);
endinterface
`default_nettype wire

### hdl/rse_front.sv
`default_nettype none
module rse_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  rse_in_if.sink              in_s,
  output rse_pkg::q_head_t    head_o,
  input  wire logic           pop_i
);

  rse_pkg::item_t mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic           push;

  assign in_s.ready   = (cnt_q != 2'd2);
  assign push         = in_s.valid && in_s.ready;
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = mem_q[rptr_q];

  // store beats in arrival order
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q].data_byte <= in_s.data_byte;
      mem_q[wptr_q].last_data <= in_s.last_data;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      if (push && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push && pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule
`default_nettype wire

### hdl/rse_back.sv
`default_nettype none
module rse_back #(
  parameter int unsigned MAX_PARITY = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rse_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rse_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire rse_pkg::q_head_t             head_i,
  output logic                              pop_o,
  rse_out_if.source                         out_m
);

  localparam int unsigned NW = $clog2(MAX_PARITY + 1);

  typedef enum logic [1:0] {ST_INIT, ST_BUILD, ST_RUN} state_e;

  state_e                        state_q;
  logic [rse_pkg::PcW-1:0]       pc_q;
  logic [rse_pkg::SymW-1:0]      poly_q;
  logic [rse_pkg::SymW-1:0]      root_q;
  logic [NW-1:0]                 bcnt_q;
  logic [NW-1:0]                 ocnt_q;
  logic [NW-1:0]                 n_eff;
  logic [rse_pkg::SymW-1:0]      gen_q  [MAX_PARITY+1];
  logic [rse_pkg::SymW-1:0]      gen_d  [MAX_PARITY+1];
  logic [rse_pkg::SymW-1:0]      rem_q  [MAX_PARITY];
  logic [rse_pkg::SymW-1:0]      rem_d  [MAX_PARITY];
  logic [rse_pkg::SymW-1:0]      snap_q [MAX_PARITY];
  logic [rse_pkg::SymW-1:0]      fb;
  logic                          cfg_hit;
  logic                          drain_free;
  logic                          out_take;
  logic                          load;

  // clamp the parity count into one to MAX_PARITY
  always_comb begin
    if (pc_q == '0) n_eff = NW'(1);
    else if (int'(pc_q) > int'(MAX_PARITY)) n_eff = NW'(MAX_PARITY);
    else n_eff = NW'(pc_q);
  end

  // one generator root step over all coefficients at once
  always_comb begin
    for (int i = 0; i < MAX_PARITY; i++) begin
      if (NW'(i) < n_eff)
        gen_d[i] = gen_q[i+1] ^ rse_pkg::gf_mul(root_q, gen_q[i], poly_q);
      else if (NW'(i) == n_eff)
        gen_d[i] = rse_pkg::gf_mul(root_q, gen_q[i], poly_q);
      else
        gen_d[i] = gen_q[i];
    end
    if (n_eff == NW'(MAX_PARITY))
      gen_d[MAX_PARITY] = rse_pkg::gf_mul(root_q, gen_q[MAX_PARITY], poly_q);
    else
      gen_d[MAX_PARITY] = gen_q[MAX_PARITY];
  end

  // remainder shift with feedback; taps above the degree see zero coefficients
  assign fb = head_i.item.data_byte ^ rem_q[0];
  always_comb begin
    for (int i = 0; i < MAX_PARITY - 1; i++)
      rem_d[i] = rem_q[i+1] ^ rse_pkg::gf_mul(gen_q[i+1], fb, poly_q);
    rem_d[MAX_PARITY-1] = rse_pkg::gf_mul(gen_q[MAX_PARITY], fb, poly_q);
  end

  assign cfg_hit = cfg_we_i && (cfg_idx_i == rse_pkg::REG_PARITY_COUNT ||
                                cfg_idx_i == rse_pkg::REG_FIELD_POLY);
  assign out_take   = out_m.valid && out_m.ready;
  assign drain_free = (ocnt_q == '0) || ((ocnt_q == NW'(1)) && out_m.ready);
  assign pop_o      = (state_q == ST_RUN) && head_i.valid &&
                      (!head_i.item.last_data || drain_free);
  assign load       = pop_o && head_i.item.last_data;

  assign out_m.valid       = (ocnt_q != '0);
  assign out_m.parity_byte = snap_q[0];
  assign out_m.last_parity = (ocnt_q == NW'(1));

  // hold generator and parity snapshot
  always_ff @(posedge clk_i) begin
    if (state_q == ST_INIT) begin
      for (int i = 0; i <= MAX_PARITY; i++)
        gen_q[i] <= (NW'(i) == n_eff) ? 8'h01 : 8'h00;
    end else if (state_q == ST_BUILD) begin
      gen_q <= gen_d;
    end
    if (load) begin
      snap_q <= rem_d;
    end else if (out_take) begin
      for (int i = 0; i < MAX_PARITY - 1; i++) snap_q[i] <= snap_q[i+1];
    end
  end

  // control: registers, build sequencer, remainder, drain count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      pc_q    <= rse_pkg::PARITY_RESET;
      poly_q  <= rse_pkg::POLY_RESET;
      root_q  <= 8'h01;
      bcnt_q  <= '0;
      ocnt_q  <= '0;
      for (int i = 0; i < MAX_PARITY; i++) rem_q[i] <= '0;
    end else begin
      if (load) ocnt_q <= n_eff;
      else if (out_take) ocnt_q <= ocnt_q - NW'(1);
      if (pop_o) begin
        for (int i = 0; i < MAX_PARITY; i++)
          rem_q[i] <= head_i.item.last_data ? 8'h00 : rem_d[i];
      end
      case (state_q)
        ST_INIT: begin
          root_q  <= 8'h01;
          bcnt_q  <= '0;
          state_q <= ST_BUILD;
        end
        ST_BUILD: begin
          root_q <= rse_pkg::gf_mul(root_q, 8'h02, poly_q);
          bcnt_q <= bcnt_q + NW'(1);
          if (bcnt_q == n_eff - NW'(1)) state_q <= ST_RUN;
        end
        ST_RUN: ;
        default: state_q <= ST_INIT;
      endcase
      if (cfg_hit) begin
        if (cfg_idx_i == rse_pkg::REG_PARITY_COUNT)
          pc_q <= cfg_data_i[rse_pkg::PcW-1:0];
        else
          poly_q <= cfg_data_i;
        for (int i = 0; i < MAX_PARITY; i++) rem_q[i] <= '0;
        state_q <= ST_INIT;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/reed_solomon_systematic_encoder.sv
`default_nettype none
// Message beats are taken one per cycle into a two-entry queue while it has
// room; the back end updates all remainder taps at once, so throughput is one
// byte a cycle; a rebuild stalls it and a last byte waits for the drain. After
// the last message byte, n parity beats follow one per cycle while accepted.
// Reset, or a write to either register, rebuilds the generator one root per
// cycle; parity_count resets to 8 and field_poly to 0x1d.
module reed_solomon_systematic_encoder #(
  parameter int unsigned MAX_PARITY = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  rse_in_if.sink                            data_in,
  rse_out_if.source                         parity_out,
  input  wire logic                         cfg_we_i,
  input  wire logic [rse_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rse_pkg::CfgDataW-1:0] cfg_data_i
);

  rse_pkg::q_head_t head;
  logic             pop;

  rse_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_s   (data_in),
    .head_o (head),
    .pop_i  (pop)
  );

  rse_back #(.MAX_PARITY(MAX_PARITY)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .head_i     (head),
    .pop_o      (pop),
    .out_m      (parity_out)
  );

endmodule
`default_nettype wire
